@@ hdl/lsa_pkg.sv @@
// ============================================================================
// lsa_pkg: shared types and constants for layer run segment average
// Request payload structs, FSM state type, and sizing constants.
// ============================================================================
`default_nettype none

package lsa_pkg;

    // Curve length bound and the index ceiling that follows from it
    localparam int MAX_SAMPLES = 65536;
    localparam int INDEX_W     = 16;
    localparam logic [INDEX_W-1:0] INDEX_CAP =
        (MAX_SAMPLES - 1 > 65535) ? 16'hFFFF : INDEX_W'(MAX_SAMPLES - 1);

    // Run accumulator sizing
    localparam int SUM_W   = 48;
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_CAP = 17'h10000;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = COUNT_W - 1;

    typedef struct packed {
        logic [15:0]        layer_code;
        logic signed [31:0] sample_value;
        logic [31:0]        sample_depth;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic [31:0]        top_depth;
        logic [31:0]        bottom_depth;
        logic [15:0]        top_index;
        logic [15:0]        bottom_index;
        logic signed [31:0] layer_average;
        logic signed [31:0] top_value;
        logic               final_layer;
    } layer_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } lsa_state_t;

endpackage

`default_nettype wire

@@ hdl/layer_run_segment_average_top.sv @@
// ============================================================================
// layer_run_segment_average_top: well-log layer run averaging
// Groups samples into runs of equal layer code and reports each closed run
// with its bounds and the mean of its values (serial signed division).
// ============================================================================
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------
//  sample  | in        | sample_valid / sample_ready | lsa_pkg::sample_t
//  layer   | out       | layer_valid  / layer_ready  | lsa_pkg::layer_t
//
//  A closing sample loads the 48-bit restoring divider, which yields one
//  quotient bit per cycle; the result then moves into the output register
//  as soon as that register is free.
//  sample_ready is low while the divider runs and while a finished result
//  waits for a full output register. The output register holds one result
//  so the next sample is taken while the previous layer is still pending.
//  Asynchronous reset clears run state and control; no clearing pass.
// ============================================================================
`default_nettype none

module layer_run_segment_average_top
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire lsa_pkg::sample_t  sample,
    output logic                   layer_valid,
    input  wire logic              layer_ready,
    output lsa_pkg::layer_t        layer
);
    import lsa_pkg::*;

    // State and registers
    lsa_state_t state_reg, state_next;

    logic [15:0]              run_code_reg,      run_code_next;
    logic [31:0]              run_top_depth_reg, run_top_depth_next;
    logic [INDEX_W-1:0]       run_top_index_reg, run_top_index_next;
    logic [31:0]              run_top_value_reg, run_top_value_next;
    logic signed [SUM_W-1:0]  run_sum_reg,       run_sum_next;
    logic [COUNT_W-1:0]       run_count_reg,     run_count_next;
    logic [INDEX_W-1:0]       next_index_reg,    next_index_next;

    layer_t                   pend_reg,          pend_next;
    logic                     neg_reg,           neg_next;
    logic [SUM_W-1:0]         quo_reg,           quo_next;
    logic [REM_W-1:0]         rem_reg,           rem_next;
    logic [COUNT_W-1:0]       dvsr_reg,          dvsr_next;
    logic [STEP_W-1:0]        step_reg,          step_next;

    layer_t                   out_reg,           out_next;
    logic                     out_valid_reg,     out_valid_next;

    // Handshake and decode
    logic                     accept;
    logic                     closing;
    logic                     out_free;
    logic                     div_last;
    logic                     load_out;
    logic signed [SUM_W-1:0]  value_ext;
    logic [COUNT_W-1:0]       rem_sh;
    logic [COUNT_W:0]         trial;
    logic [SUM_W-1:0]         quo_signed;

    assign accept    = sample_valid && sample_ready;
    assign closing   = (run_count_reg != '0) &&
                       ((sample.layer_code != run_code_reg) || sample.last_sample);
    assign out_free  = !out_valid_reg || layer_ready;
    assign div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign value_ext = SUM_W'(sample.sample_value);

    // One restoring division step
    assign rem_sh     = {rem_reg, quo_reg[SUM_W-1]};
    assign trial      = {1'b0, rem_sh} - {1'b0, dvsr_reg};
    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid && closing)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State-driven outputs
    always_comb
    begin
        sample_ready = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:  sample_ready = 1'b1;
            ST_DIV:   load_out     = 1'b0;
            ST_DONE:  load_out     = out_free;
            default:  sample_ready = 1'b0;
        endcase
    end

    // Run bookkeeping on an accepted request
    always_comb
    begin
        run_code_next      = run_code_reg;
        run_top_depth_next = run_top_depth_reg;
        run_top_index_next = run_top_index_reg;
        run_top_value_next = run_top_value_reg;
        run_sum_next       = run_sum_reg;
        run_count_next     = run_count_reg;
        next_index_next    = next_index_reg;
        if (accept)
        begin
            if (closing || (run_count_reg == '0))
            begin
                run_code_next      = sample.layer_code;
                run_top_depth_next = sample.sample_depth;
                run_top_index_next = next_index_reg;
                run_top_value_next = sample.sample_value;
                run_sum_next       = value_ext;
                run_count_next     = COUNT_W'(1);
            end
            else if (run_count_reg < COUNT_CAP)
            begin
                run_sum_next   = run_sum_reg + value_ext;
                run_count_next = run_count_reg + COUNT_W'(1);
            end
            // last sample returns the block to a fresh curve
            if (sample.last_sample)
            begin
                run_code_next      = '0;
                run_top_depth_next = '0;
                run_top_index_next = '0;
                run_top_value_next = '0;
                run_sum_next       = '0;
                run_count_next     = '0;
                next_index_next    = '0;
            end
            else if (next_index_reg < INDEX_CAP)
            begin
                next_index_next = next_index_reg + INDEX_W'(1);
            end
        end
    end

    // Divider load and iteration
    always_comb
    begin
        pend_next = pend_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        step_next = step_reg;
        if (accept && closing)
        begin
            pend_next.top_depth     = run_top_depth_reg;
            pend_next.bottom_depth  = sample.sample_depth;
            pend_next.top_index     = run_top_index_reg;
            pend_next.bottom_index  = next_index_reg;
            pend_next.layer_average = '0;
            pend_next.top_value     = run_top_value_reg;
            pend_next.final_layer   = sample.last_sample;
            neg_next  = run_sum_reg[SUM_W-1];
            quo_next  = run_sum_reg[SUM_W-1] ? (~run_sum_reg + SUM_W'(1)) : run_sum_reg;
            rem_next  = '0;
            dvsr_next = run_count_reg;
            step_next = '0;
        end
        else if (state_reg == ST_DIV)
        begin
            step_next = step_reg + STEP_W'(1);
            if (!trial[COUNT_W])
            begin
                rem_next = trial[REM_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[REM_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // Output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !layer_ready;
        if (load_out)
        begin
            out_next               = pend_reg;
            out_next.layer_average = quo_signed[31:0];
            out_valid_next         = 1'b1;
        end
    end

    // Control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            run_code_reg      <= '0;
            run_top_depth_reg <= '0;
            run_top_index_reg <= '0;
            run_top_value_reg <= '0;
            run_sum_reg       <= '0;
            run_count_reg     <= '0;
            next_index_reg    <= '0;
            step_reg          <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            run_code_reg      <= run_code_next;
            run_top_depth_reg <= run_top_depth_next;
            run_top_index_reg <= run_top_index_next;
            run_top_value_reg <= run_top_value_next;
            run_sum_reg       <= run_sum_next;
            run_count_reg     <= run_count_next;
            next_index_reg    <= next_index_next;
            step_reg          <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        out_reg  <= out_next;
    end

    assign layer_valid = out_valid_reg;
    assign layer       = out_reg;

endmodule

`default_nettype wire
